// ===== rtl/iet_pkg.sv =====
// Package for the interval event table: widths, opcodes, controller states
// and the command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none
package iet_pkg;

  localparam int SLOTS_DEFAULT = 256;
  localparam logic [8:0] LOOP_DEFAULT = 9'd16;
  localparam int PAYLOAD_W = 21;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FIND   = 3'd2,
    OP_NTH    = 3'd3,
    OP_SETLEN = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FREE_RD,
    ST_FREE_EV,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic mod_step;   // one subtract step of the modulo reduction
    logic idx_clr;    // slot index to zero
    logic idx_inc;    // slot index plus one
    logic rd;         // issue memory read at index
    logic evaluate;   // act on read data for current op
    logic free_eval;  // look for free slot in add pass two
    logic clr_step;   // clear the live bit at index
    logic finish;     // register the result beat
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       reject;    // add rejected up front
    logic       mod_done;
    logic       idx_last;
    logic       stop;      // scan may end early (match found)
    logic       kept;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/iet_ctrl.sv =====
// Controller for the interval event table: sequences the slot scans.
// Depends on iet_pkg.
`default_nettype none
module iet_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output iet_pkg::dp_cmd_t      cmd,
  input  wire iet_pkg::dp_sts_t sts
);

  iet_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= iet_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != iet_pkg::ST_IDLE);
    unique case (state_r)
      iet_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt = iet_pkg::ST_MOD;
        end
      end
      iet_pkg::ST_MOD: begin
        // inputs are in registers now; route by op
        if (sts.op == iet_pkg::OP_CLEAR) begin
          state_nxt = iet_pkg::ST_CLEAR;
        end else if (sts.op == iet_pkg::OP_ADD && sts.reject) begin
          state_nxt = iet_pkg::ST_DONE;
        end else if (sts.op == iet_pkg::OP_ADD || sts.op == iet_pkg::OP_REMOVE ||
                     sts.op == iet_pkg::OP_NTH || sts.op == iet_pkg::OP_SETLEN) begin
          cmd.rd = 1'b1;
          state_nxt = iet_pkg::ST_SCAN_RD;
        end else if (sts.op == iet_pkg::OP_FIND) begin
          if (sts.mod_done) begin
            cmd.rd = 1'b1;
            state_nxt = iet_pkg::ST_SCAN_RD;
          end else begin
            cmd.mod_step = 1'b1;
          end
        end else begin
          state_nxt = iet_pkg::ST_DONE;
        end
      end
      iet_pkg::ST_SCAN_RD: state_nxt = iet_pkg::ST_SCAN_EV;
      iet_pkg::ST_SCAN_EV: begin
        cmd.evaluate = 1'b1;
        if (sts.stop) begin
          state_nxt = iet_pkg::ST_DONE;
        end else if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          if (sts.op == iet_pkg::OP_ADD && !sts.kept) begin
            cmd.rd = 1'b1;
            state_nxt = iet_pkg::ST_FREE_RD;
          end else begin
            state_nxt = iet_pkg::ST_DONE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = iet_pkg::ST_SCAN_RD;
        end
      end
      iet_pkg::ST_FREE_RD: state_nxt = iet_pkg::ST_FREE_EV;
      iet_pkg::ST_FREE_EV: begin
        cmd.free_eval = 1'b1;
        if (sts.stop || sts.idx_last) begin
          state_nxt = iet_pkg::ST_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = iet_pkg::ST_FREE_RD;
        end
      end
      iet_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.idx_last) state_nxt = iet_pkg::ST_DONE;
        else cmd.idx_inc = 1'b1;
      end
      iet_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = iet_pkg::ST_IDLE;
      end
      default: state_nxt = iet_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/iet_dp.sv =====
// Datapath for the interval event table: slot memory, live bits, counters
// and result register. Depends on iet_pkg.
`default_nettype none
module iet_dp #(
  parameter int SLOTS = iet_pkg::SLOTS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire iet_pkg::dp_cmd_t cmd,
  output iet_pkg::dp_sts_t      sts,
  input  wire logic [2:0]       in_op,
  input  wire logic [15:0]      in_step_value,
  input  wire logic [8:0]       in_span,
  input  wire logic [7:0]       in_nth,
  input  wire logic [3:0]       in_degree,
  input  wire logic [3:0]       in_quality,
  input  wire logic [3:0]       in_ext_bits,
  input  wire logic [1:0]       in_inversion_sel,
  input  wire logic [6:0]       in_loudness,
  output logic                  out_valid,
  output logic                  out_ok,
  output logic [7:0]            out_hit_start,
  output logic [8:0]            out_hit_span,
  output logic [3:0]            out_hit_degree,
  output logic [3:0]            out_hit_quality,
  output logic [3:0]            out_hit_ext,
  output logic [1:0]            out_hit_inversion,
  output logic [6:0]            out_hit_loudness,
  output logic [8:0]            out_live_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = iet_pkg::PAYLOAD_W;
  localparam logic [8:0] LOOP_MAX = (SLOTS < 256) ? 9'(SLOTS) : 9'd256;
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  // memory: start, span, payload per slot
  logic [8+9+PW-1:0] mem [SLOTS];
  logic [8+9+PW-1:0] rd_r;
  logic [SLOTS-1:0]  live_r;
  logic              live_rd_r;

  logic [IW-1:0]  idx_r;
  logic [2:0]     op_r;
  logic [15:0]    sv_r;
  logic [8:0]     span_r;
  logic [7:0]     nth_r;
  logic [PW-1:0]  pay_r;
  logic [15:0]    qs_r;      // find query step, shifted out msb first
  logic [8:0]     rem_r;     // query step modulo loop length
  logic [4:0]     mcnt_r;    // bits of the query step consumed
  logic [8:0]     cnt_r;     // nth ordinal counter
  logic [8:0]     loop_r;
  logic [8:0]     live_tot_r;
  logic           kept_r;
  logic           ok_r;
  logic           hit_r;
  logic [8+9+PW-1:0] hit_d_r;

  // derived add range
  logic [16:0] raw_end;
  logic [8:0]  end_c, nspan;
  logic        reject;
  assign raw_end = {1'b0, sv_r} + 17'(span_r);
  assign end_c   = (raw_end > 17'(loop_r)) ? loop_r : raw_end[8:0];
  assign nspan   = end_c - sv_r[8:0];
  assign reject  = (span_r == 9'd0) || (sv_r >= 16'(loop_r));

  // restoring remainder, one step bit per cycle
  logic [9:0] rem_sh;
  assign rem_sh = {rem_r, qs_r[15]};

  // current slot fields
  logic [7:0]  s_start;
  logic [8:0]  s_span, s_end;
  logic [9:0]  s_raw;
  logic [PW-1:0] s_pay;
  assign s_start = rd_r[8+9+PW-1 -: 8];
  assign s_span  = rd_r[9+PW-1 -: 9];
  assign s_pay   = rd_r[PW-1:0];
  assign s_raw   = 10'(s_start) + 10'(s_span);
  assign s_end   = (s_raw > 10'(loop_r)) ? loop_r : s_raw[8:0];

  logic overlap, same, rm_hit, find_hit, nth_hit, len_drop;
  assign overlap  = live_rd_r && (9'(s_start) < end_c) && (s_end > sv_r[8:0]);
  assign same     = (s_start == sv_r[7:0]) && (s_span == nspan) &&
                    (s_pay[3:0] == pay_r[3:0]);
  assign rm_hit   = live_rd_r && (16'(s_start) == sv_r);
  assign find_hit = live_rd_r && (9'(s_start) <= rem_r) && (rem_r < s_end);
  assign nth_hit  = live_rd_r && (cnt_r == 9'(nth_r));
  assign len_drop = live_rd_r && (9'(s_start) >= loop_r);

  always_comb begin
    sts = '0;
    sts.op = op_r;
    sts.reject = reject;
    sts.mod_done = (mcnt_r == 5'd16);
    sts.idx_last = (idx_r == IDX_LAST);
    // a match in the last slot counts before kept_r catches up
    sts.kept = kept_r || (cmd.evaluate && op_r == iet_pkg::OP_ADD && overlap && same);
    if (cmd.free_eval) sts.stop = !live_rd_r;
    else begin
      unique case (op_r)
        iet_pkg::OP_REMOVE: sts.stop = rm_hit;
        iet_pkg::OP_FIND:   sts.stop = find_hit;
        iet_pkg::OP_NTH:    sts.stop = nth_hit;
        default:            sts.stop = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd || cmd.idx_inc || cmd.idx_clr) begin
      rd_r <= mem[cmd.idx_clr ? '0 : (cmd.idx_inc ? idx_r + 1'b1 : idx_r)];
    end
    if (cmd.free_eval && !live_rd_r) mem[idx_r] <= {sv_r[7:0], nspan, pay_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      sv_r   <= in_step_value;
      qs_r   <= in_step_value;
      rem_r  <= '0;
      mcnt_r <= '0;
      span_r <= in_span;
      nth_r  <= in_nth;
      pay_r  <= {in_loudness, in_inversion_sel, in_ext_bits, in_quality, in_degree};
    end else if (cmd.mod_step) begin
      qs_r   <= {qs_r[14:0], 1'b0};
      rem_r  <= (rem_sh >= 10'(loop_r)) ? 9'(rem_sh - 10'(loop_r)) : rem_sh[8:0];
      mcnt_r <= mcnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      live_r <= '0;
      live_rd_r <= 1'b0;
      loop_r <= iet_pkg::LOOP_DEFAULT;
      live_tot_r <= '0;
      kept_r <= 1'b0;
      ok_r <= 1'b0;
      hit_r <= 1'b0;
      cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.rd || cmd.idx_inc || cmd.idx_clr)
        live_rd_r <= live_r[cmd.idx_clr ? '0 : (cmd.idx_inc ? idx_r + 1'b1 : idx_r)];
      if (cmd.load) begin
        kept_r <= 1'b0;
        ok_r <= 1'b0;
        hit_r <= 1'b0;
        cnt_r <= '0;
      end
      if (cmd.evaluate) begin
        unique case (op_r)
          iet_pkg::OP_ADD: begin
            if (overlap) begin
              if (same) kept_r <= 1'b1;
              else begin
                live_r[idx_r] <= 1'b0;
                live_tot_r <= live_tot_r - 9'd1;
              end
            end
          end
          iet_pkg::OP_REMOVE: if (rm_hit) begin
            live_r[idx_r] <= 1'b0;
            live_tot_r <= live_tot_r - 9'd1;
            ok_r <= 1'b1;
          end
          iet_pkg::OP_FIND: if (find_hit) begin
            hit_r <= 1'b1;
            hit_d_r <= rd_r;
          end
          iet_pkg::OP_NTH: begin
            if (nth_hit) begin
              hit_r <= 1'b1;
              hit_d_r <= rd_r;
            end else if (live_rd_r) cnt_r <= cnt_r + 9'd1;
          end
          iet_pkg::OP_SETLEN: if (len_drop) begin
            live_r[idx_r] <= 1'b0;
            live_tot_r <= live_tot_r - 9'd1;
          end
          default: ;
        endcase
      end
      // new length takes effect before the drop scan
      if (cmd.rd && !cmd.idx_clr && op_r == iet_pkg::OP_SETLEN && idx_r == '0 &&
          !cmd.evaluate) begin
        if (sv_r == 16'd0) loop_r <= 9'd1;
        else if (sv_r > 16'(LOOP_MAX)) loop_r <= LOOP_MAX;
        else loop_r <= sv_r[8:0];
      end
      if (cmd.free_eval && !live_rd_r) begin
        live_r[idx_r] <= 1'b1;
        live_tot_r <= live_tot_r + 9'd1;
        ok_r <= 1'b1;
      end
      if (cmd.clr_step) begin
        live_r[idx_r] <= 1'b0;
        live_tot_r <= '0;
        loop_r <= iet_pkg::LOOP_DEFAULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_live_count <= live_tot_r;
      unique case (op_r)
        iet_pkg::OP_ADD:    out_ok <= !reject && (kept_r || ok_r);
        iet_pkg::OP_REMOVE: out_ok <= ok_r;
        iet_pkg::OP_FIND,
        iet_pkg::OP_NTH:    out_ok <= hit_r;
        iet_pkg::OP_SETLEN,
        iet_pkg::OP_CLEAR:  out_ok <= 1'b1;
        default:            out_ok <= 1'b0;
      endcase
      if (hit_r && (op_r == iet_pkg::OP_FIND || op_r == iet_pkg::OP_NTH)) begin
        out_hit_start     <= hit_d_r[8+9+PW-1 -: 8];
        out_hit_span      <= hit_d_r[9+PW-1 -: 9];
        out_hit_degree    <= hit_d_r[3:0];
        out_hit_quality   <= hit_d_r[7:4];
        out_hit_ext       <= hit_d_r[11:8];
        out_hit_inversion <= hit_d_r[13:12];
        out_hit_loudness  <= hit_d_r[20:14];
      end else begin
        out_hit_start     <= '0;
        out_hit_span      <= '0;
        out_hit_degree    <= '0;
        out_hit_quality   <= '0;
        out_hit_ext       <= '0;
        out_hit_inversion <= '0;
        out_hit_loudness  <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/interval_event_table_top.sv =====
// Top level of the interval event table: controller plus datapath.
// Depends on iet_pkg, iet_ctrl, iet_dp.
//
// Usage: raise start with an op and its fields while busy is low; the beat
// is taken at that edge and busy goes high. When the op completes, one
// result beat appears on the out_ ports for a single cycle with out_valid
// high; the receiver cannot stall it, it must take it then.
// Sequence per op: clear steps through every slot; remove, find, nth and set
// loop length scan the slots with one read and one evaluate state per slot
// (remove, find and nth end the scan early on a match); find first reduces
// the step modulo the loop length, one step bit at a time; add runs an eviction
// pass, then a free slot pass. The single-port slot memory read sets the pace.
// Reset (synchronous, rst_n low) empties the table, sets the loop length
// to 16 and returns the controller to idle; slot contents stay undefined.
`default_nettype none
module interval_event_table_top #(
  parameter int SLOTS = iet_pkg::SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [15:0] in_step_value,
  input  wire logic [8:0]  in_span,
  input  wire logic [7:0]  in_nth,
  input  wire logic [3:0]  in_degree,
  input  wire logic [3:0]  in_quality,
  input  wire logic [3:0]  in_ext_bits,
  input  wire logic [1:0]  in_inversion_sel,
  input  wire logic [6:0]  in_loudness,
  output logic             out_valid,
  output logic             out_ok,
  output logic [7:0]       out_hit_start,
  output logic [8:0]       out_hit_span,
  output logic [3:0]       out_hit_degree,
  output logic [3:0]       out_hit_quality,
  output logic [3:0]       out_hit_ext,
  output logic [1:0]       out_hit_inversion,
  output logic [6:0]       out_hit_loudness,
  output logic [8:0]       out_live_count
);

  iet_pkg::dp_cmd_t cmd;
  iet_pkg::dp_sts_t sts;

  iet_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  iet_dp #(.SLOTS(SLOTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_step_value     (in_step_value),
    .in_span           (in_span),
    .in_nth            (in_nth),
    .in_degree         (in_degree),
    .in_quality        (in_quality),
    .in_ext_bits       (in_ext_bits),
    .in_inversion_sel  (in_inversion_sel),
    .in_loudness       (in_loudness),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_hit_start     (out_hit_start),
    .out_hit_span      (out_hit_span),
    .out_hit_degree    (out_hit_degree),
    .out_hit_quality   (out_hit_quality),
    .out_hit_ext       (out_hit_ext),
    .out_hit_inversion (out_hit_inversion),
    .out_hit_loudness  (out_hit_loudness),
    .out_live_count    (out_live_count)
  );

endmodule
`default_nettype wire
